>>> hdl/tbpr_pkg.sv
// Package for the tile background pixel renderer.
// Holds the item structs, register index codes and memory sizes; no dependencies.
package tbpr_pkg;

  localparam int VRAM_BYTES     = 8192;
  localparam int VRAM_ADDR_W    = $clog2(VRAM_BYTES);
  localparam int MAP_DEPTH      = 2048;
  localparam int MAP_ADDR_W     = $clog2(MAP_DEPTH);
  localparam int PLANE_DEPTH    = VRAM_BYTES / 2;
  localparam int PLANE_ADDR_W   = $clog2(PLANE_DEPTH);
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 8;

  // The tile maps live in the top quarter of video RAM.
  localparam logic [1:0] MAP_REGION = 2'b11;
  // Word address of tile number -128 (0x80) in signed tile mode; tile zero is at 0x800.
  localparam logic [PLANE_ADDR_W-1:0] SIGNED_WORD_BASE = PLANE_ADDR_W'(12'h400);
  localparam logic [7:0] TILE_SIGN_FLIP = 8'h80;

  localparam logic [CFG_IDX_W-1:0] CFG_BG_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_DATA   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_MAP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_PALETTE  = 3'd5;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_RENDER = 1'b1;

  typedef struct packed {
    logic                   mode;
    logic [VRAM_ADDR_W-1:0] vram_offset;
    logic [7:0]             write_byte;
    logic [7:0]             scanline;
    logic [7:0]             screen_column;
  } in_item_t;

  typedef struct packed {
    logic [7:0] map_x;
    logic [7:0] map_y;
    logic [1:0] colour_index;
    logic [1:0] shade;
  } out_item_t;

endpackage

>>> hdl/tbpr_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// A read of the address being written in the same cycle returns the old data.
module tbpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/tile_background_pixel_renderer.sv
// Top level of the tile background pixel renderer.
// Uses tbpr_pkg for types and constants and tbpr_ram for the video RAM banks.
//
// Usage:
//   An item is transferred on a clock edge where start is high and busy is low.
//   A write item (mode 0) stores write_byte at vram_offset and gives no result.
//   A render item (mode 1) gives one result via the tile map read, bitplane
//   read and output register, shown for one cycle with out_strobe high, or
//   none while the background is disabled. The receiver cannot stall; every
//   result must be taken as shown. Items may start on any cycle that busy is
//   low: one item per clock is sustained, as each of the two dependent memory
//   reads (tile map, then bitplanes) has its own pipeline stage and RAM read port.
//   Video RAM is kept in three banks: one copy of the tile map area and two
//   banks holding the even (low plane) and odd (high plane) bytes. Every write
//   goes to the bank or banks that cover its address.
//   Configuration registers are written through cfg_valid/cfg_index/cfg_data;
//   cfg_ready is always high. Write them only while no render is in flight.
//   Reset (rst_n low, synchronous) clears the registers and the pipeline and
//   holds busy high for one cycle after release. Video RAM is not cleared; a
//   read of a byte never written returns whatever the RAM holds.
module tile_background_pixel_renderer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  tbpr_pkg::in_item_t              in_item,
  output logic                            out_strobe,
  output tbpr_pkg::out_item_t             out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tbpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tbpr_pkg::CFG_DATA_W-1:0] cfg_data
);

  import tbpr_pkg::*;

  logic       bg_enable_r;
  logic       tile_data_sel_r;
  logic       tile_map_sel_r;
  logic [7:0] scroll_x_r;
  logic [7:0] scroll_y_r;
  logic [7:0] bg_palette_r;
  logic       busy_r;

  logic       accept;
  logic       write_acc;
  logic       render_acc;
  logic [7:0] mx;
  logic [7:0] my;

  logic                    map_we;
  logic                    lo_we;
  logic                    hi_we;
  logic [MAP_ADDR_W-1:0]   map_raddr;
  logic [7:0]              map_rdata;
  logic [PLANE_ADDR_W-1:0] plane_raddr;
  logic [7:0]              lo_rdata;
  logic [7:0]              hi_rdata;

  logic       s1_valid_r;
  logic [7:0] s1_mx_r;
  logic [7:0] s1_my_r;
  logic       s2_valid_r;
  logic [7:0] s2_mx_r;
  logic [7:0] s2_my_r;

  logic [7:0] tile_flip;
  logic [2:0] bit_sel;
  logic [1:0] colour;
  logic [1:0] shade;

  logic      out_strobe_r;
  out_item_t out_item_r;

  assign busy      = busy_r;
  assign cfg_ready = 1'b1;
  assign accept     = start && !busy_r;
  assign write_acc  = accept && (in_item.mode == MODE_WRITE);
  assign render_acc = accept && (in_item.mode == MODE_RENDER);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_enable_r     <= 1'b0;
      tile_data_sel_r <= 1'b0;
      tile_map_sel_r  <= 1'b0;
      scroll_x_r      <= 8'd0;
      scroll_y_r      <= 8'd0;
      bg_palette_r    <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BG_ENABLE:  bg_enable_r     <= cfg_data[0];
        CFG_TILE_DATA:  tile_data_sel_r <= cfg_data[0];
        CFG_TILE_MAP:   tile_map_sel_r  <= cfg_data[0];
        CFG_SCROLL_X:   scroll_x_r      <= cfg_data;
        CFG_SCROLL_Y:   scroll_y_r      <= cfg_data;
        CFG_BG_PALETTE: bg_palette_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // Stage 0: scroll and tile map lookup.
  assign mx        = in_item.screen_column + scroll_x_r;
  assign my        = in_item.scanline + scroll_y_r;
  assign map_raddr = {tile_map_sel_r, my[7:3], mx[7:3]};

  assign map_we = write_acc &&
                  (in_item.vram_offset[VRAM_ADDR_W-1 -: 2] == MAP_REGION);
  assign lo_we  = write_acc && !in_item.vram_offset[0];
  assign hi_we  = write_acc && in_item.vram_offset[0];

  // Writes land at the same stage as the map read, so a later render always
  // sees them. A write transferred in the cycle after a render hits the plane
  // banks on the same edge as that render's plane read, which returns old data.
  tbpr_ram #(.WIDTH(8), .DEPTH(MAP_DEPTH)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (in_item.vram_offset[MAP_ADDR_W-1:0]),
    .wdata (in_item.write_byte),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  tbpr_ram #(.WIDTH(8), .DEPTH(PLANE_DEPTH)) u_lo_ram (
    .clk   (clk),
    .we    (lo_we),
    .waddr (in_item.vram_offset[VRAM_ADDR_W-1:1]),
    .wdata (in_item.write_byte),
    .raddr (plane_raddr),
    .rdata (lo_rdata)
  );

  tbpr_ram #(.WIDTH(8), .DEPTH(PLANE_DEPTH)) u_hi_ram (
    .clk   (clk),
    .we    (hi_we),
    .waddr (in_item.vram_offset[VRAM_ADDR_W-1:1]),
    .wdata (in_item.write_byte),
    .raddr (plane_raddr),
    .rdata (hi_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= render_acc && bg_enable_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_mx_r <= mx;
    s1_my_r <= my;
  end

  // Stage 1: tile number to bitplane word address (one word per tile row).
  assign tile_flip = map_rdata ^ TILE_SIGN_FLIP;

  always_comb begin
    if (tile_data_sel_r) begin
      plane_raddr = PLANE_ADDR_W'({map_rdata, s1_my_r[2:0]});
    end else begin
      plane_raddr = SIGNED_WORD_BASE + PLANE_ADDR_W'({tile_flip, s1_my_r[2:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_mx_r <= s1_mx_r;
    s2_my_r <= s1_my_r;
  end

  // Stage 2: pick the pixel bit, leftmost pixel in bit 7, and map the colour.
  assign bit_sel = ~s2_mx_r[2:0];
  assign colour  = {hi_rdata[bit_sel], lo_rdata[bit_sel]};

  always_comb begin
    case (colour)
      2'd0:    shade = bg_palette_r[1:0];
      2'd1:    shade = bg_palette_r[3:2];
      2'd2:    shade = bg_palette_r[5:4];
      2'd3:    shade = bg_palette_r[7:6];
      default: shade = bg_palette_r[1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r.map_x        <= s2_mx_r;
    out_item_r.map_y        <= s2_my_r;
    out_item_r.colour_index <= colour;
    out_item_r.shade        <= shade;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // An enabled render transfer always gives a result with out_strobe high.
  a_render_result: assert property (@(posedge clk) disable iff (!rst_n)
    (render_acc && bg_enable_r) |-> ##3 out_strobe)
    else $error("render transfer produced no result");

  // Write transfers never produce a result.
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    write_acc |-> ##3 !out_strobe)
    else $error("write transfer produced a result");

  // A byte write lands in exactly one of the plane banks.
  a_plane_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    write_acc |-> $onehot({lo_we, hi_we}))
    else $error("byte write did not select a single plane bank");

  // The map bank only takes writes that also go to a plane bank.
  a_map_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    map_we |-> (lo_we || hi_we))
    else $error("tile map write without plane bank write");

endmodule
